### rtl/core/qri_pkg.sv
package qri_pkg;

  localparam int unsigned QUAT_WIDTH_DEF = 16;
  localparam int unsigned RATE_WIDTH_DEF = 16;
  localparam int unsigned STEP_WIDTH     = 16;
  localparam logic [STEP_WIDTH-1:0] TIME_STEP_RESET = 16'd1092;
  localparam logic       CMD_LOAD      = 1'b1;
  localparam logic       REG_TIME_STEP = 1'b0;
  localparam int unsigned TERM_COUNT   = 12;
  localparam int unsigned RATE_COUNT   = 3;
  localparam int unsigned LANE_COUNT   = 4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_LOAD,
    OP_SCALE,
    OP_MUL,
    OP_UPDATE,
    OP_SQUARE,
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_KEEP,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_SCALE,
    ST_MUL,
    ST_UPDATE,
    ST_SQUARE,
    ST_CHECK,
    ST_ROOT,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_END,
    ST_KEEP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic zero;
  } dp_status_t;

  typedef struct packed {
    logic [1:0] p_sel;
    logic [1:0] q_sel;
    logic [1:0] r_sel;
    logic       neg;
  } term_t;

  // hamilton product terms of p * q, component order x y z w
  function automatic term_t term_sel(input logic [3:0] idx);
    term_t t;
    case (idx)
      4'd0:    t = '{p_sel: 2'd0, q_sel: 2'd3, r_sel: 2'd0, neg: 1'b0};
      4'd1:    t = '{p_sel: 2'd1, q_sel: 2'd2, r_sel: 2'd0, neg: 1'b0};
      4'd2:    t = '{p_sel: 2'd2, q_sel: 2'd1, r_sel: 2'd0, neg: 1'b1};
      4'd3:    t = '{p_sel: 2'd1, q_sel: 2'd3, r_sel: 2'd1, neg: 1'b0};
      4'd4:    t = '{p_sel: 2'd2, q_sel: 2'd0, r_sel: 2'd1, neg: 1'b0};
      4'd5:    t = '{p_sel: 2'd0, q_sel: 2'd2, r_sel: 2'd1, neg: 1'b1};
      4'd6:    t = '{p_sel: 2'd2, q_sel: 2'd3, r_sel: 2'd2, neg: 1'b0};
      4'd7:    t = '{p_sel: 2'd0, q_sel: 2'd1, r_sel: 2'd2, neg: 1'b0};
      4'd8:    t = '{p_sel: 2'd1, q_sel: 2'd0, r_sel: 2'd2, neg: 1'b1};
      4'd9:    t = '{p_sel: 2'd0, q_sel: 2'd0, r_sel: 2'd3, neg: 1'b1};
      4'd10:   t = '{p_sel: 2'd1, q_sel: 2'd1, r_sel: 2'd3, neg: 1'b1};
      4'd11:   t = '{p_sel: 2'd2, q_sel: 2'd2, r_sel: 2'd3, neg: 1'b1};
      default: t = '{p_sel: 2'd0, q_sel: 2'd0, r_sel: 2'd0, neg: 1'b0};
    endcase
    return t;
  endfunction

endpackage

### rtl/core/quaternion_rate_integrator_top.sv
// channel  | direction | payload
// s_*      | in        | tdata: omega_x, omega_y, omega_z, load_x, load_y, load_z, load_w; tuser: cmd
// m_*      | out       | tdata: quat_x, quat_y, quat_z, quat_w; tuser: zero_length
// apb      | in/out    | time_step at byte address 0
//
// a load takes the given quaternion as it is; an integrate runs through a single shared
// multiplier and divider: the multiplier, then, unless the squared length is zero, the
// bit-serial square root and the four one-bit-per-cycle divisions, one for each lane
// reset gives the identity quaternion and time_step 1092
// one item is computed at a time; a result still waiting on m_tready holds the next
// item in its emit step until the transfer completes
module quaternion_rate_integrator_top #(
  parameter int unsigned QUAT_WIDTH = qri_pkg::QUAT_WIDTH_DEF,
  parameter int unsigned RATE_WIDTH = qri_pkg::RATE_WIDTH_DEF,
  localparam int unsigned IN_DW  = ((3 * RATE_WIDTH + 4 * QUAT_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((4 * QUAT_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  // omega_x, omega_y, omega_z, load_x, load_y, load_z, load_w
  input  logic [IN_DW-1:0]  s_tdata_i,
  // cmd
  input  logic [0:0]        s_tuser_i,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  // quat_x, quat_y, quat_z, quat_w
  output logic [OUT_DW-1:0] m_tdata_o,
  // zero_length
  output logic [0:0]        m_tuser_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import qri_pkg::*;

  localparam int Q = QUAT_WIDTH;
  localparam int R = RATE_WIDTH;

  logic [STEP_WIDTH-1:0] time_step_q;
  dp_cmd_t               cmd;
  dp_status_t            status;
  logic signed [Q-1:0]   qx, qy, qz, qw;
  logic                  zero_length;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIME_STEP) ? 32'(time_step_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TIME_STEP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TIME_STEP)) begin
      time_step_q <= pwdata[STEP_WIDTH-1:0];
    end
  end

  qri_ctrl #(
    .QUAT_WIDTH(QUAT_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  qri_datapath #(
    .QUAT_WIDTH(QUAT_WIDTH),
    .RATE_WIDTH(RATE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .time_step_i   (time_step_q),
    .cmd_load_i    (s_tuser_i[0]),
    .omega_x_i     ($signed(s_tdata_i[0 +: R])),
    .omega_y_i     ($signed(s_tdata_i[R +: R])),
    .omega_z_i     ($signed(s_tdata_i[2*R +: R])),
    .load_x_i      ($signed(s_tdata_i[3*R +: Q])),
    .load_y_i      ($signed(s_tdata_i[3*R+Q +: Q])),
    .load_z_i      ($signed(s_tdata_i[3*R+2*Q +: Q])),
    .load_w_i      ($signed(s_tdata_i[3*R+3*Q +: Q])),
    .quat_x_o      (qx),
    .quat_y_o      (qy),
    .quat_z_o      (qz),
    .quat_w_o      (qw),
    .zero_length_o (zero_length)
  );

  assign m_tdata_o = OUT_DW'({qw, qz, qy, qx});
  assign m_tuser_o = zero_length;

endmodule

### rtl/core/qri_ctrl.sv
module qri_ctrl #(
  parameter int unsigned QUAT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  qri_pkg::dp_status_t status_i,
  output qri_pkg::dp_cmd_t    cmd_o
);
  import qri_pkg::*;

  localparam int unsigned SQ_W   = (2 * QUAT_WIDTH + 2 > 64) ? 64 : 2 * QUAT_WIDTH + 2;
  localparam int unsigned RT     = SQ_W / 2;
  localparam int unsigned DN     = 2 * QUAT_WIDTH - 2;
  localparam int unsigned MAX_IT = (RT > DN) ? RT : DN;
  localparam int unsigned IT_W   = $clog2(MAX_IT);

  state_e           state_q, state_d;
  logic [3:0]       idx_q, idx_d;
  logic [IT_W-1:0]  it_q, it_d;
  logic             valid_q, valid_d;
  logic             emit;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    it_d    = it_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        idx_d   = '0;
        state_d = status_i.is_load ? ST_LOAD : ST_SCALE;
      end
      ST_LOAD: state_d = ST_EMIT;
      ST_SCALE: begin
        if (idx_q == 4'(RATE_COUNT - 1)) begin
          idx_d   = '0;
          state_d = ST_MUL;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      ST_MUL: begin
        if (idx_q == 4'(TERM_COUNT - 1)) begin
          idx_d   = '0;
          state_d = ST_UPDATE;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      ST_UPDATE: state_d = ST_SQUARE;
      ST_SQUARE: begin
        if (idx_q == 4'(LANE_COUNT - 1)) begin
          idx_d   = '0;
          state_d = ST_CHECK;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      ST_CHECK: begin
        it_d    = '0;
        state_d = status_i.zero ? ST_KEEP : ST_ROOT;
      end
      ST_ROOT: begin
        if (it_q == IT_W'(RT - 1)) begin
          idx_d   = '0;
          state_d = ST_DIV_INIT;
        end else begin
          it_d = it_q + 1'b1;
        end
      end
      ST_DIV_INIT: begin
        it_d    = '0;
        state_d = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        if (it_q == IT_W'(DN - 1)) state_d = ST_DIV_END;
        else it_d = it_q + 1'b1;
      end
      ST_DIV_END: begin
        if (idx_q == 4'(LANE_COUNT - 1)) begin
          state_d = ST_EMIT;
        end else begin
          idx_d   = idx_q + 4'd1;
          state_d = ST_DIV_INIT;
        end
      end
      ST_KEEP: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.idx  = idx_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    emit       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LATCH;
      end
      ST_LOAD:     cmd_o.op = OP_LOAD;
      ST_SCALE:    cmd_o.op = OP_SCALE;
      ST_MUL:      cmd_o.op = OP_MUL;
      ST_UPDATE:   cmd_o.op = OP_UPDATE;
      ST_SQUARE:   cmd_o.op = OP_SQUARE;
      ST_CHECK:    cmd_o.op = OP_ROOT_INIT;
      ST_ROOT:     cmd_o.op = OP_ROOT_STEP;
      ST_DIV_INIT: cmd_o.op = OP_DIV_INIT;
      ST_DIV_STEP: cmd_o.op = OP_DIV_STEP;
      ST_DIV_END:  cmd_o.op = OP_DIV_END;
      ST_KEEP:     cmd_o.op = OP_KEEP;
      ST_EMIT: begin
        if (!valid_q || out_ready_i) begin
          cmd_o.op = OP_EMIT;
          emit     = 1'b1;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (emit) valid_d = 1'b1;
  end

  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      it_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      it_q    <= it_d;
      valid_q <= valid_d;
    end
  end

endmodule

### rtl/core/qri_datapath.sv
module qri_datapath #(
  parameter int unsigned QUAT_WIDTH = 16,
  parameter int unsigned RATE_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  qri_pkg::dp_cmd_t                     cmd_i,
  output qri_pkg::dp_status_t                  status_o,
  input  logic [qri_pkg::STEP_WIDTH-1:0]       time_step_i,
  input  logic                                 cmd_load_i,
  input  logic signed [RATE_WIDTH-1:0]         omega_x_i,
  input  logic signed [RATE_WIDTH-1:0]         omega_y_i,
  input  logic signed [RATE_WIDTH-1:0]         omega_z_i,
  input  logic signed [QUAT_WIDTH-1:0]         load_x_i,
  input  logic signed [QUAT_WIDTH-1:0]         load_y_i,
  input  logic signed [QUAT_WIDTH-1:0]         load_z_i,
  input  logic signed [QUAT_WIDTH-1:0]         load_w_i,
  output logic signed [QUAT_WIDTH-1:0]         quat_x_o,
  output logic signed [QUAT_WIDTH-1:0]         quat_y_o,
  output logic signed [QUAT_WIDTH-1:0]         quat_z_o,
  output logic signed [QUAT_WIDTH-1:0]         quat_w_o,
  output logic                                 zero_length_o
);
  import qri_pkg::*;

  localparam int Q     = QUAT_WIDTH;
  localparam int R     = RATE_WIDTH;
  localparam int QF    = Q - 2;
  localparam int SHIFT = R - Q + 10;
  localparam int SH_R  = (SHIFT > 0) ? SHIFT : 0;
  localparam int SH_L  = (SHIFT < 0) ? -SHIFT : 0;
  localparam int MA    = (R > Q) ? R : Q;
  localparam int MB    = (Q > STEP_WIDTH + 1) ? Q : STEP_WIDTH + 1;
  localparam int MP    = MA + MB;
  localparam int VW    = MP + SH_L;
  localparam int TW    = Q + 2;
  localparam int AW    = Q + 4;
  localparam int SQ_W  = (2 * Q + 2 > 64) ? 64 : 2 * Q + 2;
  localparam int RT    = SQ_W / 2;
  localparam int DN    = 2 * Q - 2;
  localparam logic signed [Q-1:0] QMAX = {1'b0, {(Q-1){1'b1}}};
  localparam logic signed [Q-1:0] QMIN = {1'b1, {(Q-1){1'b0}}};
  localparam logic signed [Q-1:0] QONE = Q'(1) <<< QF;

  logic                    is_load_q;
  logic signed [R-1:0]     om_q   [RATE_COUNT];
  logic signed [Q-1:0]     ld_q   [LANE_COUNT];
  logic signed [Q-1:0]     q_q    [LANE_COUNT];
  logic signed [Q-1:0]     p_q    [RATE_COUNT];
  logic signed [AW-1:0]    acc_q  [LANE_COUNT];
  logic signed [Q-1:0]     n_q    [LANE_COUNT];
  logic signed [Q-1:0]     nrm_q  [LANE_COUNT];
  logic signed [Q-1:0]     out_q  [LANE_COUNT];
  logic [SQ_W:0]           sum_q;
  logic [SQ_W-1:0]         rad_q;
  logic [RT-1:0]           root_q;
  logic [RT+1:0]           srem_q;
  logic [DN-1:0]           num_q;
  logic [RT:0]             drem_q;
  logic                    zero_q;
  logic                    out_zero_q;

  term_t                   term;
  logic [1:0]              lane;
  logic signed [MA-1:0]    ma;
  logic signed [MB-1:0]    mb;
  logic signed [MP-1:0]    prod;
  logic signed [VW-1:0]    scaled;
  logic signed [Q-1:0]     scaled_sat;
  logic signed [TW-1:0]    term_v;
  logic signed [Q-1:0]     n_new  [LANE_COUNT];
  logic [RT+1:0]           srem_n;
  logic [RT+1:0]           trial;
  logic [RT:0]             drem_n;
  logic signed [Q:0]       neg_ext;
  logic [Q-1:0]            mag;
  logic [DN-Q:0]           quot_hi;
  logic signed [Q-1:0]     quot_sat;

  assign term = term_sel(cmd_i.idx);
  assign lane = cmd_i.idx[1:0];

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_SCALE: begin
        ma = MA'(om_q[lane]);
        mb = MB'($signed({1'b0, time_step_i}));
      end
      OP_MUL: begin
        ma = MA'(p_q[term.p_sel]);
        mb = MB'(q_q[term.q_sel]);
      end
      OP_SQUARE: begin
        ma = MA'(n_q[lane]);
        mb = MB'(n_q[lane]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod   = ma * mb;
  assign scaled = (VW'(prod) <<< SH_L) >>> SH_R;
  assign scaled_sat = (scaled > QMAX) ? QMAX : (scaled < QMIN) ? QMIN : scaled[Q-1:0];
  assign term_v = $signed(prod[QF +: TW]);

  always_comb begin
    logic signed [Q-1:0] rs;
    logic signed [Q:0]   s;
    for (int i = 0; i < LANE_COUNT; i++) begin
      rs = (acc_q[i] > QMAX) ? QMAX : (acc_q[i] < QMIN) ? QMIN : acc_q[i][Q-1:0];
      s  = (Q+1)'(q_q[i]) + (Q+1)'(rs >>> 1);
      n_new[i] = (s > QMAX) ? QMAX : (s < QMIN) ? QMIN : s[Q-1:0];
    end
  end

  assign srem_n = {srem_q[RT-1:0], rad_q[SQ_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign drem_n = {drem_q[RT-1:0], num_q[DN-1]};

  assign neg_ext = -((Q+1)'(n_q[lane]));
  assign mag     = n_q[lane][Q-1] ? neg_ext[Q-1:0] : n_q[lane];
  assign quot_hi = num_q[DN-1:Q-1];

  always_comb begin
    if (n_q[lane][Q-1]) begin
      if ((quot_hi > (DN-Q+1)'(1)) || ((quot_hi == (DN-Q+1)'(1)) && |num_q[Q-2:0])) begin
        quot_sat = QMIN;
      end else begin
        quot_sat = -$signed(num_q[Q-1:0]);
      end
    end else begin
      quot_sat = (|quot_hi) ? QMAX : $signed(num_q[Q-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_COUNT; i++) q_q[i] <= '0;
      q_q[3] <= QONE;
    end else if (cmd_i.op == OP_EMIT) begin
      for (int i = 0; i < LANE_COUNT; i++) q_q[i] <= nrm_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        is_load_q <= (cmd_load_i == CMD_LOAD);
        om_q[0]   <= omega_x_i;
        om_q[1]   <= omega_y_i;
        om_q[2]   <= omega_z_i;
        ld_q[0]   <= load_x_i;
        ld_q[1]   <= load_y_i;
        ld_q[2]   <= load_z_i;
        ld_q[3]   <= load_w_i;
      end
      OP_LOAD: begin
        for (int i = 0; i < LANE_COUNT; i++) nrm_q[i] <= ld_q[i];
        zero_q <= 1'b0;
      end
      OP_SCALE: begin
        p_q[lane] <= scaled_sat;
        if (cmd_i.idx == '0) begin
          for (int i = 0; i < LANE_COUNT; i++) acc_q[i] <= '0;
        end
      end
      OP_MUL: begin
        acc_q[term.r_sel] <= term.neg ? acc_q[term.r_sel] - AW'(term_v)
                                      : acc_q[term.r_sel] + AW'(term_v);
      end
      OP_UPDATE: begin
        for (int i = 0; i < LANE_COUNT; i++) n_q[i] <= n_new[i];
        sum_q <= '0;
      end
      OP_SQUARE: sum_q <= sum_q + (SQ_W+1)'(prod[2*Q-2:0]);
      OP_ROOT_INIT: begin
        rad_q  <= sum_q[SQ_W] ? '1 : sum_q[SQ_W-1:0];
        root_q <= '0;
        srem_q <= '0;
        zero_q <= 1'b0;
      end
      OP_ROOT_STEP: begin
        rad_q <= rad_q << 2;
        if (srem_n >= trial) begin
          srem_q <= srem_n - trial;
          root_q <= {root_q[RT-2:0], 1'b1};
        end else begin
          srem_q <= srem_n;
          root_q <= {root_q[RT-2:0], 1'b0};
        end
      end
      OP_DIV_INIT: begin
        num_q  <= {mag, {QF{1'b0}}};
        drem_q <= '0;
      end
      OP_DIV_STEP: begin
        if (drem_n >= {1'b0, root_q}) begin
          drem_q <= drem_n - {1'b0, root_q};
          num_q  <= {num_q[DN-2:0], 1'b1};
        end else begin
          drem_q <= drem_n;
          num_q  <= {num_q[DN-2:0], 1'b0};
        end
      end
      OP_DIV_END: nrm_q[lane] <= quot_sat;
      OP_KEEP: begin
        for (int i = 0; i < LANE_COUNT; i++) nrm_q[i] <= q_q[i];
        zero_q <= 1'b1;
      end
      OP_EMIT: begin
        for (int i = 0; i < LANE_COUNT; i++) out_q[i] <= nrm_q[i];
        out_zero_q <= zero_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o.is_load = is_load_q;
  assign status_o.zero    = (sum_q == '0);

  assign quat_x_o      = out_q[0];
  assign quat_y_o      = out_q[1];
  assign quat_z_o      = out_q[2];
  assign quat_w_o      = out_q[3];
  assign zero_length_o = out_zero_q;

endmodule

### tb/sv/tb_quaternion_rate_integrator_top.sv
module tb_quaternion_rate_integrator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qri_pkg::*;

  localparam int QW = 16;
  localparam int QF = QW - 2;
  localparam int RF = 8;
  localparam int STEP_SHIFT = RF + 16 - QF;
  localparam int IN_DW = ((3 * 16 + 4 * QW + 7) / 8) * 8;
  localparam int OUT_DW = ((4 * QW + 7) / 8) * 8;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic       cmd;
    logic [15:0] wx, wy, wz;
    logic [15:0] lx, ly, lz, lw;
  } rate_item_t;

  typedef struct packed {
    logic [15:0] qx, qy, qz, qw;
    logic        zlen;
  } quat_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid_i = 1'b0;
  logic s_tready_o;
  logic [IN_DW-1:0] s_tdata_i = '0;
  logic [0:0] s_tuser_i = '0;
  logic m_tvalid_o;
  logic m_tready_i = 1'b0;
  logic [OUT_DW-1:0] m_tdata_o;
  logic [0:0] m_tuser_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  quaternion_rate_integrator_top uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rate_item_t pending_items[$];
  quat_res_t  expected_quats[$];
  longint     orient[4];
  longint     step_cfg;
  int         mismatches = 0;
  int         idle_cycles = 0;
  bit         hold_sender = 1'b0;
  bit         long_stall_req = 1'b0;
  bit         timed_out = 1'b0;
  bit         in_taken = 1'b0;

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint fl_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mulfx(longint a, longint b);
    return (a * b) >>> QF;
  endfunction

  function automatic longint root64(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic quat_res_t integrate_orientation(rate_item_t it);
    quat_res_t r;
    longint p[3], q[4], h[4], n[4], len, mag;
    longint unsigned sum;
    r.zlen = 1'b0;
    if (it.cmd == CMD_LOAD) begin
      orient[0] = longint'($signed(it.lx));
      orient[1] = longint'($signed(it.ly));
      orient[2] = longint'($signed(it.lz));
      orient[3] = longint'($signed(it.lw));
    end else begin
      p[0] = sat16(fl_shift(longint'($signed(it.wx)) * step_cfg, STEP_SHIFT));
      p[1] = sat16(fl_shift(longint'($signed(it.wy)) * step_cfg, STEP_SHIFT));
      p[2] = sat16(fl_shift(longint'($signed(it.wz)) * step_cfg, STEP_SHIFT));
      for (int i = 0; i < 4; i++) q[i] = orient[i];
      h[0] = sat16(mulfx(p[0], q[3]) + mulfx(p[1], q[2]) - mulfx(p[2], q[1]));
      h[1] = sat16(mulfx(p[1], q[3]) + mulfx(p[2], q[0]) - mulfx(p[0], q[2]));
      h[2] = sat16(mulfx(p[2], q[3]) + mulfx(p[0], q[1]) - mulfx(p[1], q[0]));
      h[3] = sat16(-mulfx(p[0], q[0]) - mulfx(p[1], q[1]) - mulfx(p[2], q[2]));
      sum = 0;
      for (int i = 0; i < 4; i++) begin
        n[i] = sat16(q[i] + fl_shift(h[i], 1));
        sum += longint'(n[i] * n[i]);
      end
      if (sum == 0) begin
        r.zlen = 1'b1;
      end else begin
        len = root64(sum);
        for (int i = 0; i < 4; i++) begin
          mag = n[i] < 0 ? -n[i] : n[i];
          mag = (mag << QF) / len;
          orient[i] = sat16(n[i] < 0 ? -mag : mag);
        end
      end
    end
    r.qx = orient[0][15:0];
    r.qy = orient[1][15:0];
    r.qz = orient[2][15:0];
    r.qw = orient[3][15:0];
    return r;
  endfunction

  // input transfer seen at the last rising edge
  always @(posedge clk_i) begin
    in_taken <= s_tvalid_i && s_tready_o;
  end

  // driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && !in_taken) begin
        // keep offering
      end else if (pending_items.size() != 0 && !hold_sender && gap_left == 0) begin
        rate_item_t it;
        it = pending_items.pop_front();
        s_tvalid_i <= 1'b1;
        s_tuser_i <= it.cmd;
        s_tdata_i <= {it.lw, it.lz, it.ly, it.lx, it.wz, it.wy, it.wx};
        expected_quats.push_back(integrate_orientation(it));
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 300);
      end else begin
        s_tvalid_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // receiver stall pattern
  int stall_left = 0;
  int stall_phase = 0;
  always @(negedge clk_i) begin
    if (long_stall_req && stall_left == 0) begin
      stall_left = 3000;
      long_stall_req = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready_i <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 512;
      if (stall_phase < 128) m_tready_i <= 1'b1;
      else m_tready_i <= ($urandom_range(0, 3) != 0) ? 1'b1 : ($urandom_range(0, 40) == 0);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid_o && m_tready_i) begin
        if (expected_quats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer %h", m_tdata_o);
        end else begin
          quat_res_t e;
          e = expected_quats.pop_front();
          if (m_tdata_o[15:0] !== e.qx || m_tdata_o[31:16] !== e.qy ||
              m_tdata_o[47:32] !== e.qz || m_tdata_o[63:48] !== e.qw ||
              m_tuser_o[0] !== e.zlen) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x %h y %h z %h w %h zl %b, got %h zl %b",
                       e.qx, e.qy, e.qz, e.qw, e.zlen, m_tdata_o, m_tuser_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_step(input logic [15:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {16'h0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    step_cfg = val;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || s_tvalid_i || expected_quats.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic rate_item_t rand_item(bit cmd, int mag);
    rate_item_t it;
    it.cmd = cmd;
    it.wx = $urandom; it.wy = $urandom; it.wz = $urandom;
    it.lx = $urandom; it.ly = $urandom; it.lz = $urandom; it.lw = $urandom;
    if (mag == 0) begin
      it.wx = 16'($signed($urandom_range(0, 1023)) - 512);
      it.wy = 16'($signed($urandom_range(0, 1023)) - 512);
      it.wz = 16'($signed($urandom_range(0, 1023)) - 512);
    end else if (mag == 1 && cmd) begin
      it.lx = 16'($signed($urandom_range(0, 16384)) - 8192);
      it.ly = 16'($signed($urandom_range(0, 16384)) - 8192);
      it.lz = 16'($signed($urandom_range(0, 16384)) - 8192);
      it.lw = 16'($signed($urandom_range(0, 16384)) - 8192);
    end
    return it;
  endfunction

  function automatic rate_item_t mk(bit cmd, logic [15:0] a, b, c, x, y, z, w);
    rate_item_t it;
    it.cmd = cmd; it.wx = a; it.wy = b; it.wz = c;
    it.lx = x; it.ly = y; it.lz = z; it.lw = w;
    return it;
  endfunction

  logic [15:0] step_set[5] = '{16'd0, 16'hFFFF, 16'd1, 16'd1092, 16'd20000};

  initial begin
    orient[0] = 0; orient[1] = 0; orient[2] = 0; orient[3] = 64'sd1 << QF;
    step_cfg = TIME_STEP_RESET;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed
    pending_items.push_back(mk(1'b0, 16'h0100, 16'h0000, 16'h0000, 16'hFFFF, 0, 0, 0));
    pending_items.push_back(mk(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0));
    pending_items.push_back(mk(1'b0, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0));
    pending_items.push_back(mk(1'b1, 16'hFFFF, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    pending_items.push_back(mk(1'b0, 16'h7FFF, 16'h8000, 16'h1234, 0, 0, 0, 0));
    pending_items.push_back(mk(1'b1, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    pending_items.push_back(mk(1'b0, 16'h8000, 16'h7FFF, 16'h0001, 0, 0, 0, 0));
    pending_items.push_back(mk(1'b1, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 0, 0, 0));
    pending_items.push_back(mk(1'b0, 16'h4000, 16'hC000, 16'h2000, 0, 0, 0, 0));
    pending_items.push_back(mk(1'b1, 0, 0, 0, 16'h0001, 0, 0, 0));
    pending_items.push_back(mk(1'b0, 16'h0100, 16'h0100, 16'h0100, 0, 0, 0, 0));
    pending_items.push_back(mk(1'b1, 0, 0, 0, 0, 0, 0, 16'h4000));
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_step(step_set[ph]);
      for (int k = 0; k < 270; k++) begin
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) pending_items.push_back(rand_item(1'b1, $urandom_range(1, 2)));
        else pending_items.push_back(rand_item(1'b0, r < 6 ? 0 : 2));
        if (ph == 1 && k == 40) begin
          while (pending_items.size() != 0 || s_tvalid_i) @(posedge clk_i);
          hold_sender = 1'b1;
          while (expected_quats.size() != 0) @(posedge clk_i);
          hold_sender = 1'b0;
        end
        if (ph == 2 && k == 20) long_stall_req = 1'b1;
      end
      drain();
    end
    if (mismatches == 0 && expected_quats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
